// ----- design/assert_macros.svh -----
// Assertion helpers shared by the motor encoder block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- design/dcmeb_pkg.sv -----
package dcmeb_pkg;

    localparam int COUNT_W = 32;
    localparam int DUTY_W  = 8;
    localparam int CFG_W   = 16;
    localparam int MS_W    = 16;
    localparam int RPM_W   = 32;
    localparam int SCALE_W = 16;
    localparam int QUOT_W  = 47;
    localparam int STEP_W  = 6;
    localparam int QDEPTH  = 2;

    localparam logic [DUTY_W-1:0]  DUTY_MAX      = '1;
    localparam logic [SCALE_W-1:0] RPM_SCALE     = 16'd60000;
    localparam logic [CFG_W-1:0]   TPR_RESET     = 16'd1;
    localparam logic [CFG_W-1:0]   INTERVAL_RESET = 16'd1000;

    typedef enum logic [2:0] {
        K_EDGE      = 3'd0,
        K_TICK      = 3'd1,
        K_RIGHT     = 3'd2,
        K_LEFT      = 3'd3,
        K_OFF       = 3'd4,
        K_BRAKE     = 3'd5,
        K_RESET_POS = 3'd6,
        K_NONE      = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        MODE_LEFT  = 2'd0,
        MODE_RIGHT = 2'd1,
        MODE_OFF   = 2'd2
    } t_mode;

    typedef enum logic {
        REG_TPR      = 1'b0,
        REG_INTERVAL = 1'b1
    } t_reg;

    typedef struct packed {
        t_kind             kind;
        logic              enc_b;
        logic [DUTY_W-1:0] pwm;
    } t_entry;

    typedef struct packed {
        logic [CFG_W-1:0] tpr;
        logic [CFG_W-1:0] interval;
    } t_cfg;

    typedef struct packed {
        logic [COUNT_W-1:0] diff;
        logic [MS_W-1:0]    elapsed;
        logic [CFG_W-1:0]   tpr;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic [RPM_W-1:0] rpm;
    } t_div_stat;

    typedef struct packed {
        logic [DUTY_W-1:0]  right_pwm;
        logic [DUTY_W-1:0]  left_pwm;
        logic [1:0]         mode;
        logic               braking;
        logic               moving;
        logic [COUNT_W-1:0] position;
        logic [RPM_W-1:0]   speed_rpm;
        logic               speed_new;
    } t_result;

endpackage

// ----- design/dc_motor_encoder_brake_speed.sv -----
// DC motor drive with encoder position tracking, reverse braking and rpm
// measurement. Each transaction on the input stream yields exactly one result
// transaction showing the drive state after it. Inputs land in a two-entry
// queue and are executed one per cycle while the output is free and no
// measurement is in progress; a millisecond tick that completes a measurement
// goes through the iterative divider instead (sign fix, two multiplies, 47
// restoring steps, saturation), during which the queue holds further
// transactions. Registers are written over APB: ticks per rotation at 0x0,
// measurement interval in milliseconds at 0x4.
`include "assert_macros.svh"

module dc_motor_encoder_brake_speed (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // encoder_b, speed_pwm[7:0], pad
    input  logic [2:0]  s_axis_tuser,  // kind[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // right_pwm, left_pwm, mode[1:0], braking, moving, position[31:0],
    // speed_rpm[31:0], pad
    output logic [87:0] m_axis_tdata,
    output logic [0:0]  m_axis_tuser,  // speed_new
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dcmeb_pkg::t_cfg      r_cfg;
    dcmeb_pkg::t_entry    entry;
    logic                 entry_valid;
    logic                 pop;
    logic                 div_start;
    dcmeb_pkg::t_div_req  div_req;
    dcmeb_pkg::t_div_stat div_stat;
    dcmeb_pkg::t_result   res;
    dcmeb_pkg::t_reg      reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = dcmeb_pkg::t_reg'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tpr      <= dcmeb_pkg::TPR_RESET;
            r_cfg.interval <= dcmeb_pkg::INTERVAL_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_sel)
                dcmeb_pkg::REG_TPR:      r_cfg.tpr      <= pwdata[15:0];
                dcmeb_pkg::REG_INTERVAL: r_cfg.interval <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            dcmeb_pkg::REG_TPR:      prdata = {16'd0, r_cfg.tpr};
            dcmeb_pkg::REG_INTERVAL: prdata = {16'd0, r_cfg.interval};
            default:                 prdata = '0;
        endcase
    end

    dcmeb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_kind  (s_axis_tuser),
        .i_enc_b (s_axis_tdata[0]),
        .i_pwm   (s_axis_tdata[8:1]),
        .o_valid (entry_valid),
        .o_entry (entry),
        .i_pop   (pop)
    );

    dcmeb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (entry_valid),
        .i_entry     (entry),
        .o_pop       (pop),
        .i_cfg       (r_cfg),
        .o_div_start (div_start),
        .o_div_req   (div_req),
        .i_div_stat  (div_stat),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (res)
    );

    dcmeb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_req   (div_req),
        .o_stat  (div_stat)
    );

    assign m_axis_tdata = {4'd0, res.speed_rpm, res.position, res.moving, res.braking,
                           res.mode, res.left_pwm, res.right_pwm};
    assign m_axis_tuser = res.speed_new;

    `ASSERT_IMPLY(a_div_idle_start, i_clk, i_rst_n, div_start, !div_stat.busy)

endmodule

// ----- design/dcmeb_front.sv -----
`include "assert_macros.svh"

module dcmeb_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_kind,
    input  logic                  i_enc_b,
    input  logic [dcmeb_pkg::DUTY_W-1:0] i_pwm,
    output logic                  o_valid,
    output dcmeb_pkg::t_entry     o_entry,
    input  logic                  i_pop
);

    dcmeb_pkg::t_entry r_q [dcmeb_pkg::QDEPTH];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;
    dcmeb_pkg::t_entry entry;

    always_comb begin
        entry.kind  = dcmeb_pkg::t_kind'(i_kind);
        entry.enc_b = i_enc_b;
        entry.pwm   = i_pwm;
    end

    assign o_ready = (r_cnt != 2'(dcmeb_pkg::QDEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_entry = r_q[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    `ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= 2'(dcmeb_pkg::QDEPTH))
    `ASSERT_IMPLY(a_ptr_match, i_clk, i_rst_n, (r_cnt == 2'd0) || (r_cnt == 2'd2), r_wr == r_rd)

endmodule

// ----- design/dcmeb_div.sv -----
`include "assert_macros.svh"

module dcmeb_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  dcmeb_pkg::t_div_req   i_req,
    output dcmeb_pkg::t_div_stat  o_stat
);

    typedef enum logic [4:0] {
        D_IDLE = 5'b00001,
        D_ABS  = 5'b00010,
        D_MUL  = 5'b00100,
        D_DIV  = 5'b01000,
        D_FIN  = 5'b10000
    } t_dstate;

    localparam int QW = dcmeb_pkg::QUOT_W;

    t_dstate r_state;
    logic [dcmeb_pkg::COUNT_W-1:0] r_diff;
    logic [dcmeb_pkg::COUNT_W-1:0] r_mag;
    logic                          r_neg;
    logic [dcmeb_pkg::MS_W-1:0]    r_el;
    logic [dcmeb_pkg::CFG_W-1:0]   r_tpr;
    logic [QW-1:0]                 r_quot;
    logic [31:0]                   r_rem;
    logic [31:0]                   r_div;
    logic [dcmeb_pkg::STEP_W-1:0]  r_step;
    logic [dcmeb_pkg::RPM_W-1:0]   r_rpm;

    logic [47:0] prod;
    logic [31:0] dprod;
    logic [32:0] trial;
    logic        ge;
    logic        sat;

    assign prod  = r_mag * dcmeb_pkg::RPM_SCALE;
    assign dprod = r_el * r_tpr;
    assign trial = {r_rem, r_quot[QW-1]};
    assign ge    = (trial >= {1'b0, r_div});
    assign sat   = |r_quot[QW-1:31];

    assign o_stat.busy = (r_state != D_IDLE);
    assign o_stat.rpm  = r_rpm;

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    r_diff <= i_req.diff;
                    r_el   <= (i_req.elapsed == '0) ? 16'd1 : i_req.elapsed;
                    r_tpr  <= (i_req.tpr == '0) ? 16'd1 : i_req.tpr;
                end
            end
            D_ABS: begin
                r_neg <= r_diff[dcmeb_pkg::COUNT_W-1];
                r_mag <= r_diff[dcmeb_pkg::COUNT_W-1] ? (~r_diff + 32'd1) : r_diff;
            end
            D_MUL: begin
                r_quot <= prod[QW-1:0];
                r_div  <= dprod;
                r_rem  <= '0;
                r_step <= '0;
            end
            D_DIV: begin
                r_rem  <= ge ? 32'(trial - {1'b0, r_div}) : trial[31:0];
                r_quot <= {r_quot[QW-2:0], ge};
                r_step <= r_step + 6'd1;
            end
            D_FIN: begin
                if (r_neg) begin
                    r_rpm <= sat ? 32'h8000_0000 : (~r_quot[31:0] + 32'd1);
                end else begin
                    r_rpm <= sat ? 32'h7FFF_FFFF : r_quot[31:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            unique case (r_state)
                D_IDLE: if (i_start) r_state <= D_ABS;
                D_ABS:  r_state <= D_MUL;
                D_MUL:  r_state <= D_DIV;
                D_DIV:  if (r_step == 6'(QW - 1)) r_state <= D_FIN;
                D_FIN:  r_state <= D_IDLE;
                default: r_state <= D_IDLE;
            endcase
        end
    end

    `ASSERT_IMPLY(a_start_idle, i_clk, i_rst_n, i_start, r_state == D_IDLE)
    `ASSERT_IMPLY(a_rem_below, i_clk, i_rst_n, r_state == D_DIV, r_rem < r_div)

endmodule

// ----- design/dcmeb_back.sv -----
`include "assert_macros.svh"

module dcmeb_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  dcmeb_pkg::t_entry     i_entry,
    output logic                  o_pop,
    input  dcmeb_pkg::t_cfg       i_cfg,
    output logic                  o_div_start,
    output dcmeb_pkg::t_div_req   o_div_req,
    input  dcmeb_pkg::t_div_stat  i_div_stat,
    output logic                  o_valid,
    input  logic                  i_ready,
    output dcmeb_pkg::t_result    o_result
);

    typedef enum logic [1:0] {
        S_RUN  = 2'b01,
        S_WAIT = 2'b10
    } t_bstate;

    t_bstate r_state;
    logic [dcmeb_pkg::COUNT_W-1:0] r_pos;
    logic [dcmeb_pkg::COUNT_W-1:0] r_ref;
    logic [dcmeb_pkg::MS_W-1:0]    r_ms;
    dcmeb_pkg::t_mode              r_mode;
    logic                          r_brk;
    logic [dcmeb_pkg::RPM_W-1:0]   r_speed;
    logic [dcmeb_pkg::DUTY_W-1:0]  r_right;
    logic [dcmeb_pkg::DUTY_W-1:0]  r_left;
    logic                          r_ovalid;
    dcmeb_pkg::t_result            r_res;

    logic [dcmeb_pkg::COUNT_W-1:0] n_pos;
    logic [dcmeb_pkg::MS_W-1:0]    n_ms;
    dcmeb_pkg::t_mode              n_mode;
    logic                          n_brk;
    logic [dcmeb_pkg::DUTY_W-1:0]  n_right;
    logic [dcmeb_pkg::DUTY_W-1:0]  n_left;
    logic out_free;
    logic take;
    logic measure;
    logic finish;

    assign out_free = !r_ovalid || i_ready;
    assign take     = (r_state == S_RUN) && i_valid && out_free;
    assign finish   = (r_state == S_WAIT) && !i_div_stat.busy && out_free;
    assign o_pop    = take;
    assign o_valid  = r_ovalid;
    assign o_result = r_res;

    always_comb begin
        n_pos   = r_pos;
        n_ms    = r_ms;
        n_mode  = r_mode;
        n_brk   = r_brk;
        n_right = r_right;
        n_left  = r_left;
        unique case (i_entry.kind)
            dcmeb_pkg::K_EDGE: begin
                n_pos = i_entry.enc_b ? (r_pos + 32'd1) : (r_pos - 32'd1);
            end
            dcmeb_pkg::K_TICK: begin
                if (r_ms != '1) begin
                    n_ms = r_ms + 16'd1;
                end
            end
            dcmeb_pkg::K_RIGHT: begin
                n_right = i_entry.pwm;
                n_left  = '0;
                n_mode  = dcmeb_pkg::MODE_RIGHT;
            end
            dcmeb_pkg::K_LEFT: begin
                n_left  = i_entry.pwm;
                n_right = '0;
                n_mode  = dcmeb_pkg::MODE_LEFT;
            end
            dcmeb_pkg::K_OFF: begin
                n_right = '0;
                n_left  = '0;
                n_mode  = dcmeb_pkg::MODE_OFF;
                n_brk   = 1'b0;
            end
            dcmeb_pkg::K_BRAKE: begin
                if (!r_brk && r_mode != dcmeb_pkg::MODE_OFF) begin
                    if (r_mode == dcmeb_pkg::MODE_LEFT) begin
                        n_right = dcmeb_pkg::DUTY_MAX;
                        n_left  = '0;
                        n_mode  = dcmeb_pkg::MODE_RIGHT;
                    end else begin
                        n_left  = dcmeb_pkg::DUTY_MAX;
                        n_right = '0;
                        n_mode  = dcmeb_pkg::MODE_LEFT;
                    end
                    n_brk = 1'b1;
                end
            end
            dcmeb_pkg::K_RESET_POS: begin
                n_pos = '0;
            end
            default: begin
            end
        endcase
        // release the brake once the count has moved back past the reference
        if (n_brk && ((n_mode == dcmeb_pkg::MODE_LEFT && $signed(r_ref) > $signed(n_pos)) ||
                      (n_mode == dcmeb_pkg::MODE_RIGHT && $signed(r_ref) < $signed(n_pos)))) begin
            n_right = '0;
            n_left  = '0;
            n_mode  = dcmeb_pkg::MODE_OFF;
            n_brk   = 1'b0;
        end
    end

    assign measure = (i_entry.kind == dcmeb_pkg::K_TICK) && (n_ms >= i_cfg.interval);
    assign o_div_start = take && measure;

    always_comb begin
        o_div_req.diff    = n_pos - r_ref;
        o_div_req.elapsed = n_ms;
        o_div_req.tpr     = i_cfg.tpr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_ref   <= '0;
            r_ms    <= '0;
            r_mode  <= dcmeb_pkg::MODE_OFF;
            r_brk   <= 1'b0;
            r_speed <= '0;
            r_right <= '0;
            r_left  <= '0;
        end else if (take) begin
            r_pos   <= n_pos;
            r_mode  <= n_mode;
            r_brk   <= n_brk;
            r_right <= n_right;
            r_left  <= n_left;
            if (measure) begin
                r_ref <= n_pos;
                r_ms  <= '0;
            end else begin
                r_ms  <= n_ms;
                r_res <= '{right_pwm: n_right, left_pwm: n_left, mode: n_mode,
                           braking: n_brk, moving: (n_mode != dcmeb_pkg::MODE_OFF),
                           position: n_pos, speed_rpm: r_speed, speed_new: 1'b0};
            end
        end else if (finish) begin
            r_speed <= i_div_stat.rpm;
            r_res   <= '{right_pwm: r_right, left_pwm: r_left, mode: r_mode,
                         braking: r_brk, moving: (r_mode != dcmeb_pkg::MODE_OFF),
                         position: r_pos, speed_rpm: i_div_stat.rpm, speed_new: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_RUN;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_RUN:  if (o_div_start) r_state <= S_WAIT;
                S_WAIT: if (finish) r_state <= S_RUN;
                default: r_state <= S_RUN;
            endcase
            if ((take && !measure) || finish) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    `ASSERT_IMPLY(a_off_quiet, i_clk, i_rst_n, r_mode == dcmeb_pkg::MODE_OFF, (r_right == '0) && (r_left == '0) && !r_brk)
    `ASSERT_ALWAYS(a_one_side, i_clk, i_rst_n, (r_right == '0) || (r_left == '0))
    `ASSERT_IMPLY(a_wait_no_pop, i_clk, i_rst_n, r_state == S_WAIT, !o_pop)

endmodule

// ----- sim/tb_dc_motor_encoder_brake_speed.sv -----
`timescale 1ns / 1ps

module tb_dc_motor_encoder_brake_speed;
    import dcmeb_pkg::*;

    localparam int    STALL_LIMIT = 4000;
    localparam int    DRAIN_CYCLES = 80;
    localparam longint RPM_PER_MIN = 60000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // encoder_b, speed_pwm[7:0], pad
    logic [2:0]  s_axis_tuser;   // kind[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // right_pwm, left_pwm, mode[1:0], braking, moving, position[31:0],
    // speed_rpm[31:0], pad
    logic [87:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;   // speed_new
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dc_motor_encoder_brake_speed uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    t_entry  cmd_q[$];
    t_result status_q[$];

    // drive model state
    logic [15:0]  cfg_tpr;
    logic [15:0]  cfg_interval;
    logic [31:0]  mdl_pos;
    logic [31:0]  mdl_ref;
    logic [15:0]  mdl_ms;
    t_mode        mdl_mode;
    logic         mdl_brake;
    logic [31:0]  mdl_rpm;
    logic [7:0]   mdl_right;
    logic [7:0]   mdl_left;

    bit  calm;
    int  items_queued;
    int  items_sent;
    int  results_checked;
    int  measurements;
    int  brake_releases;
    int  settings_used;
    int  bad_results;
    int  stall_cycles;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic logic [31:0] rpm_of(input logic [31:0] delta,
                                           input logic [15:0] elapsed,
                                           input logic [15:0] tpr);
        logic        neg;
        logic [31:0] mag;
        logic [63:0] a;
        logic [63:0] dv;
        logic [63:0] whole;
        logic [63:0] q;
        neg = delta[31];
        mag = neg ? (~delta + 32'd1) : delta;
        a = {32'd0, mag};
        dv = 64'((elapsed == 16'd0) ? 16'd1 : elapsed) * 64'((tpr == 16'd0) ? 16'd1 : tpr);
        whole = a / dv;
        if (whole >= 64'd35792) begin
            q = 64'h1_0000_0000;
        end else begin
            q = whole * RPM_PER_MIN + ((a % dv) * RPM_PER_MIN) / dv;
        end
        if (neg) begin
            if (q >= 64'h8000_0000) begin
                return 32'h8000_0000;
            end
            return ~q[31:0] + 32'd1;
        end
        if (q > 64'h7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    task automatic motor_stop();
        mdl_right = '0;
        mdl_left  = '0;
        mdl_mode  = MODE_OFF;
        mdl_brake = 1'b0;
    endtask

    task automatic step_motor(input t_entry it);
        t_result r;
        logic    fresh;
        case (it.kind)
            K_EDGE: begin
                mdl_pos = it.enc_b ? mdl_pos + 32'd1 : mdl_pos - 32'd1;
            end
            K_TICK: begin
                if (mdl_ms != 16'hFFFF) begin
                    mdl_ms = mdl_ms + 16'd1;
                end
            end
            K_RIGHT: begin
                mdl_right = it.pwm;
                mdl_left  = '0;
                mdl_mode  = MODE_RIGHT;
            end
            K_LEFT: begin
                mdl_left  = it.pwm;
                mdl_right = '0;
                mdl_mode  = MODE_LEFT;
            end
            K_OFF: begin
                motor_stop();
            end
            K_BRAKE: begin
                if (!mdl_brake && mdl_mode != MODE_OFF) begin
                    if (mdl_mode == MODE_LEFT) begin
                        mdl_right = DUTY_MAX;
                        mdl_left  = '0;
                        mdl_mode  = MODE_RIGHT;
                    end else begin
                        mdl_left  = DUTY_MAX;
                        mdl_right = '0;
                        mdl_mode  = MODE_LEFT;
                    end
                    mdl_brake = 1'b1;
                end
            end
            K_RESET_POS: begin
                mdl_pos = '0;
            end
            default: begin
            end
        endcase

        if (mdl_brake && mdl_mode == MODE_LEFT && $signed(mdl_pos) < $signed(mdl_ref)) begin
            motor_stop();
            brake_releases++;
        end else if (mdl_brake && mdl_mode == MODE_RIGHT
                     && $signed(mdl_ref) < $signed(mdl_pos)) begin
            motor_stop();
            brake_releases++;
        end

        fresh = 1'b0;
        if (it.kind == K_TICK && mdl_ms >= cfg_interval) begin
            mdl_rpm = rpm_of(mdl_pos - mdl_ref, mdl_ms, cfg_tpr);
            mdl_ref = mdl_pos;
            mdl_ms  = '0;
            fresh   = 1'b1;
        end

        r.right_pwm = mdl_right;
        r.left_pwm  = mdl_left;
        r.mode      = mdl_mode;
        r.braking   = mdl_brake;
        r.moving    = (mdl_mode != MODE_OFF);
        r.position  = mdl_pos;
        r.speed_rpm = mdl_rpm;
        r.speed_new = fresh;
        status_q.push_back(r);
    endtask

    // input side
    always @(posedge i_clk) begin : drive_in
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                step_motor(cmd_q[0]);
                void'(cmd_q.pop_front());
                items_sent++;
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the pending transaction
            end else if (cmd_q.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'd0, cmd_q[0].pwm, cmd_q[0].enc_b};
                s_axis_tuser  <= cmd_q[0].kind;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output side
    always @(posedge i_clk) begin : watch_out
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.right_pwm = m_axis_tdata[7:0];
                got.left_pwm  = m_axis_tdata[15:8];
                got.mode      = m_axis_tdata[17:16];
                got.braking   = m_axis_tdata[18];
                got.moving    = m_axis_tdata[19];
                got.position  = m_axis_tdata[51:20];
                got.speed_rpm = m_axis_tdata[83:52];
                got.speed_new = m_axis_tuser[0];
                if (status_q.size() == 0) begin
                    if (bad_results < 10) begin
                        $display("unexpected result: pos=%0d rpm=%0d",
                                 $signed(got.position), $signed(got.speed_rpm));
                    end
                    bad_results++;
                end else begin
                    want = status_q.pop_front();
                    results_checked++;
                    if (want.speed_new) begin
                        measurements++;
                    end
                    if (got.right_pwm !== want.right_pwm || got.left_pwm !== want.left_pwm
                        || got.mode !== want.mode || got.braking !== want.braking
                        || got.moving !== want.moving || got.position !== want.position
                        || got.speed_rpm !== want.speed_rpm
                        || got.speed_new !== want.speed_new) begin
                        if (bad_results < 10) begin
                            $display("mismatch at result %0d", results_checked);
                            $display("  exp r=%0d l=%0d mode=%0d brk=%0d mov=%0d",
                                     want.right_pwm, want.left_pwm, want.mode, want.braking,
                                     want.moving);
                            $display("      pos=%0d rpm=%0d new=%0d",
                                     $signed(want.position), $signed(want.speed_rpm),
                                     want.speed_new);
                            $display("  got r=%0d l=%0d mode=%0d brk=%0d mov=%0d",
                                     got.right_pwm, got.left_pwm, got.mode, got.braking,
                                     got.moving);
                            $display("      pos=%0d rpm=%0d new=%0d",
                                     $signed(got.position), $signed(got.speed_rpm),
                                     got.speed_new);
                        end
                        bad_results++;
                    end
                end
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 15);
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n && (cmd_q.size() != 0 || status_q.size() != 0)
            && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= stall_cycles + 1;
        end else begin
            stall_cycles <= 0;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("no transaction for %0d cycles", STALL_LIMIT);
            $display("** dc_motor_encoder_brake_speed: FAILED **");
            $finish;
        end
    end

    task automatic push_item(input t_kind k, input logic b, input logic [7:0] p);
        t_entry it;
        it.kind  = k;
        it.enc_b = b;
        it.pwm   = p;
        cmd_q.push_back(it);
        items_queued++;
    endtask

    task automatic apb_write(input t_reg r, input logic [15:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= {16'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (r == REG_TPR) begin
            cfg_tpr = v;
        end else begin
            cfg_interval = v;
        end
    endtask

    task automatic wait_idle();
        while (cmd_q.size() != 0 || status_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_drive(input logic [15:0] tpr, input logic [15:0] interval);
        wait_idle();
        apb_write(REG_TPR, tpr);
        apb_write(REG_INTERVAL, interval);
        settings_used++;
    endtask

    task automatic queue_motion(input logic dir_up, input int bias);
        if ($urandom_range(99) < 30) begin
            push_item(K_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)));
        end else begin
            push_item(K_EDGE, ($urandom_range(99) < bias) ? dir_up : !dir_up,
                      8'($urandom_range(255)));
        end
    endtask

    // turn and run, then usually brake and run back the other way
    task automatic queue_episode();
        logic go_right;
        int   n;
        go_right = 1'($urandom_range(1));
        push_item(go_right ? K_RIGHT : K_LEFT, 1'($urandom_range(1)),
                  8'($urandom_range(255)));
        n = $urandom_range(2, 12);
        repeat (n) queue_motion(go_right, 85);
        if ($urandom_range(99) < 80) begin
            push_item(K_BRAKE, 1'($urandom_range(1)), 8'($urandom_range(255)));
            if ($urandom_range(99) < 10) begin
                push_item(go_right ? K_RIGHT : K_LEFT, 1'($urandom_range(1)),
                          8'($urandom_range(255)));
            end
            n = $urandom_range(1, 16);
            repeat (n) queue_motion(!go_right, 80);
        end
        if ($urandom_range(99) < 25) begin
            push_item(K_OFF, 1'($urandom_range(1)), 8'($urandom_range(255)));
        end
    endtask

    task automatic queue_random(input int n);
        int stop_at;
        stop_at = items_queued + n;
        while (items_queued < stop_at) begin
            if ($urandom_range(99) < 70) begin
                queue_episode();
            end else begin
                push_item(t_kind'(3'($urandom_range(7))), 1'($urandom_range(1)),
                          8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cfg_tpr       = 16'd1;
        cfg_interval  = 16'd1000;
        mdl_pos       = '0;
        mdl_ref       = '0;
        mdl_ms        = '0;
        mdl_mode      = MODE_OFF;
        mdl_brake     = 1'b0;
        mdl_rpm       = '0;
        mdl_right     = '0;
        mdl_left      = '0;
        calm          = 1'b0;
        items_queued  = 0;
        items_sent    = 0;
        results_checked = 0;
        measurements  = 0;
        brake_releases = 0;
        settings_used = 1;
        bad_results   = 0;
        stall_cycles  = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_random(60);

        set_drive(16'd3, 16'd2);
        push_item(K_EDGE, 1'b1, 8'h00);
        push_item(K_EDGE, 1'b1, 8'hFF);
        push_item(K_EDGE, 1'b1, 8'h00);
        push_item(K_TICK, 1'b0, 8'h00);
        push_item(K_TICK, 1'b1, 8'hFF);
        push_item(K_EDGE, 1'b0, 8'h00);
        push_item(K_EDGE, 1'b0, 8'h00);
        push_item(K_TICK, 1'b0, 8'h00);
        push_item(K_TICK, 1'b0, 8'h00);
        push_item(K_RIGHT, 1'b0, 8'hFF);
        push_item(K_BRAKE, 1'b0, 8'h00);
        push_item(K_BRAKE, 1'b1, 8'h00);
        push_item(K_EDGE, 1'b0, 8'h00);
        push_item(K_BRAKE, 1'b0, 8'h00);
        push_item(K_LEFT, 1'b0, 8'h00);
        push_item(K_BRAKE, 1'b0, 8'h00);
        push_item(K_RIGHT, 1'b1, 8'h5A);
        push_item(K_OFF, 1'b0, 8'h00);
        push_item(K_RESET_POS, 1'b1, 8'h00);
        push_item(K_NONE, 1'b1, 8'hFF);
        push_item(K_LEFT, 1'b0, 8'hA5);
        push_item(K_TICK, 1'b0, 8'h00);
        push_item(K_TICK, 1'b0, 8'h00);

        set_drive(16'd1, 16'd1);
        queue_random(100);
        set_drive(16'd0, 16'd0);
        queue_random(100);
        set_drive(16'd65535, 16'd65535);
        queue_random(60);
        set_drive(16'd65535, 16'd1);
        queue_random(80);
        set_drive(16'($urandom_range(1, 12)), 16'($urandom_range(1, 6)));
        calm = 1'b1;
        queue_random(100);
        wait_idle();
        calm = 1'b0;
        set_drive(16'($urandom_range(1, 40)), 16'($urandom_range(1, 4)));
        queue_random(100);

        // measure a longer run upwards, then the drop back to zero
        set_drive(16'd1, 16'd1);
        calm = 1'b1;
        push_item(K_TICK, 1'b0, 8'h00);
        repeat (40) push_item(K_EDGE, 1'b1, 8'h00);
        push_item(K_TICK, 1'b0, 8'h00);
        push_item(K_RESET_POS, 1'b0, 8'h00);
        push_item(K_TICK, 1'b0, 8'h00);
        wait_idle();
        calm = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (status_q.size() != 0) begin
            $display("%0d results never arrived", status_q.size());
            bad_results += status_q.size();
        end
        $display("sent %0d transactions over %0d register settings, checked %0d results",
                 items_sent, settings_used, results_checked);
        $display("saw %0d speed measurements and %0d brake releases, %0d mismatches",
                 measurements, brake_releases, bad_results);
        if (bad_results == 0) begin
            $display("** dc_motor_encoder_brake_speed: PASSED **");
        end else begin
            $display("** dc_motor_encoder_brake_speed: FAILED **");
        end
        $finish;
    end

endmodule
